// ===== hw/rtl/msim_pkg.sv =====
// ============================================================================
// msim_pkg
// Shared types and constants for the interval membership sweep unit.
// ============================================================================
package msim_pkg;

   // Fixed field widths of the request and response transactions
   localparam int CHROM_W     = 8;
   localparam int COORD_IN_W  = 28;
   localparam int SEL_W       = 4;
   localparam int MASK_W      = 9;
   localparam int COUNT_W     = 32;
   localparam int CSR_W       = 4;
   localparam int ACTION_W    = 2;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 48;

   // Request kinds carried in req_tuser
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_QUERY  = 2'd1,
      ACT_COUNT  = 2'd2,
      ACT_REWIND = 2'd3
   } action_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_PROBE = 2'd1,
      S_CHECK = 2'd2,
      S_EMIT  = 2'd3
   } state_type;

endpackage

// ===== hw/rtl/msim_interval_ram.sv =====
// ============================================================================
// msim_interval_ram
// Single write port, single read port interval store with registered read.
// ============================================================================
module msim_interval_ram #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 64,
   parameter int DEPTH  = 8192
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/multi_set_interval_membership_sweep_unit.sv =====
// ============================================================================
// multi_set_interval_membership_sweep_unit
// Sorted interval overlap sweep over several region sets held in one RAM.
// ============================================================================
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------
//  req     | in  | req_tvalid/req_tready  | tuser action, tdata fields
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata mask, count, rejected
//  csr     | in  | csr_valid/csr_ready    | csr_data sets_in_use
//
//  Load, count read and rewind go from accept to the emit state, then to the
//  result register. Query probes each checked set in turn: when its walk
//  pointer is exhausted it moves on, else it reads the interval RAM, then
//  compares; the single interval RAM read port sets the pace.
//  Reset clears counts, pointers, hit counts and sets_in_use; the RAM is not
//  cleared. A new request is taken while a result waits in the output
//  register; a stalled result holds the sequencer in its emit state.
//
module multi_set_interval_membership_sweep_unit
   import msim_pkg::*;
#(
   parameter int NUM_SETS      = 8,
   parameter int MAX_INTERVALS = 1024,
   parameter int COORD_BITS    = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: tuser[1:0] action
   // tdata: [3:0] set_index, [11:4] chrom_index, [12] chrom_valid,
   //        [40:13] interval_start, [68:41] interval_stop, [96:69] position
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ACTION_W-1:0]    req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response tdata: [8:0] membership_mask, [40:9] count_value,
   //                 [41] load_rejected
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // sets_in_use register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_W-1:0]       csr_data
);

   localparam int CW      = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
   localparam int ENTRY_W = CHROM_W + 2 * CW;
   localparam int IDX_W   = $clog2(MAX_INTERVALS);
   localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int SN_W    = $clog2(NUM_SETS + 1);
   localparam int ADDR_W  = SET_W + IDX_W;
   localparam int DEPTH   = NUM_SETS * (2 ** IDX_W);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      sets_ff, sets_in;
   logic [CNT_W-1:0]      cnt_ff  [NUM_SETS];
   logic [CNT_W-1:0]      cnt_in  [NUM_SETS];
   logic [CNT_W-1:0]      ptr_ff  [NUM_SETS];
   logic [CNT_W-1:0]      ptr_in  [NUM_SETS];
   logic [COUNT_W-1:0]    hit_ff  [NUM_SETS+1];
   logic [COUNT_W-1:0]    hit_in  [NUM_SETS+1];
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CHROM_W-1:0]    chrom_ff, chrom_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [SN_W-1:0]       cur_set_ff, cur_set_in;
   logic [SN_W-1:0]       used_ff, used_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rej_ff, rej_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_rej_ff, rsp_rej_in;

   // ---------------------------------------------------------------------
   // Request field unpacking
   // ---------------------------------------------------------------------
   action_type            in_action;
   logic [SEL_W-1:0]      in_set;
   logic [CHROM_W-1:0]    in_chrom;
   logic                  in_chrom_valid;
   logic [CW-1:0]         in_start, in_stop, in_pos;

   assign in_action      = action_type'(req_tuser);
   assign in_set         = req_tdata[3:0];
   assign in_chrom       = req_tdata[11:4];
   assign in_chrom_valid = req_tdata[12];
   assign in_start       = req_tdata[13 +: CW];
   assign in_stop        = req_tdata[41 +: CW];
   assign in_pos         = req_tdata[69 +: CW];

   // ---------------------------------------------------------------------
   // Handshake and decode
   // ---------------------------------------------------------------------
   logic                  req_fire, out_free, emit_load, adv;
   logic                  ld_idx_ok, ld_full, ld_write, rd_idx_ok;
   logic [SET_W-1:0]      ld_k, cur_k;
   logic [SN_W-1:0]       rd_sel, used_now;
   logic [CNT_W-1:0]      ptr_cur, cnt_cur;
   logic                  have_entry, last_set;
   logic                  mem_re;
   logic [ENTRY_W-1:0]    rd_entry;
   logic [CHROM_W-1:0]    e_chrom;
   logic [CW-1:0]         e_start, e_stop;
   logic                  c_gt, c_eq, chk_hit, chk_skip;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign ld_idx_ok = (in_set != '0) && (32'(in_set) <= NUM_SETS);
   assign ld_k      = SET_W'(32'(in_set) - 32'd1);
   assign ld_full   = cnt_ff[ld_k] >= CNT_W'(MAX_INTERVALS);
   assign ld_write  = req_fire && (in_action == ACT_LOAD) && ld_idx_ok && !ld_full;
   assign rd_idx_ok = 32'(in_set) <= NUM_SETS;
   assign rd_sel    = SN_W'(in_set);
   assign used_now  = (32'(sets_ff) > NUM_SETS) ? SN_W'(NUM_SETS) : SN_W'(sets_ff);

   assign cur_k      = SET_W'(32'(cur_set_ff) - 32'd1);
   assign ptr_cur    = ptr_ff[cur_k];
   assign cnt_cur    = cnt_ff[cur_k];
   assign have_entry = ptr_cur < cnt_cur;
   assign last_set   = cur_set_ff == used_ff;

   // Stored entry layout: stop, start, chromosome from the top down
   assign e_chrom = rd_entry[CHROM_W-1:0];
   assign e_start = rd_entry[CHROM_W +: CW];
   assign e_stop  = rd_entry[CHROM_W+CW +: CW];

   // Interval compare against the current query position
   assign c_gt     = chrom_ff > e_chrom;
   assign c_eq     = chrom_ff == e_chrom;
   assign chk_hit  = c_eq && (e_start <= pos_ff) && (e_stop >= pos_ff);
   assign chk_skip = c_gt || (c_eq && (e_start <= pos_ff) && (e_stop < pos_ff));

   // ---------------------------------------------------------------------
   // Interval RAM
   // ---------------------------------------------------------------------
   msim_interval_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ld_write),
      .wr_addr ({ld_k, cnt_ff[ld_k][IDX_W-1:0]}),
      .wr_data ({in_stop, in_start, in_chrom}),
      .rd_en   (mem_re),
      .rd_addr ({cur_k, ptr_cur[IDX_W-1:0]}),
      .rd_data (rd_entry)
   );

   // ---------------------------------------------------------------------
   // Sequencer next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (in_action == ACT_QUERY && in_chrom_valid && used_now != '0) begin
                  state_in = S_PROBE;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_PROBE: begin
            if (have_entry) begin
               state_in = S_CHECK;
            end else if (last_set) begin
               state_in = S_EMIT;
            end
         end
         S_CHECK: begin
            if (chk_skip) begin
               state_in = S_PROBE;
            end else if (last_set) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      emit_load  = 1'b0;
      adv        = 1'b0;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_PROBE: begin
            mem_re = have_entry;
            adv    = !have_entry && !last_set;
         end
         S_CHECK: adv = !chk_skip && !last_set;
         S_EMIT:  emit_load = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Set state: fill counts, walk pointers, hit counts
   // ---------------------------------------------------------------------
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   always_comb begin
      sets_in = csr_valid ? csr_data : sets_ff;
      cnt_in  = cnt_ff;
      ptr_in  = ptr_ff;
      hit_in  = hit_ff;
      if (ld_write) begin
         cnt_in[ld_k] = cnt_ff[ld_k] + 1'b1;
      end
      if (req_fire && in_action == ACT_REWIND) begin
         for (int i = 0; i < NUM_SETS; i++) begin
            ptr_in[i] = '0;
         end
         for (int i = 0; i <= NUM_SETS; i++) begin
            hit_in[i] = '0;
         end
      end
      if (req_fire && in_action == ACT_QUERY) begin
         hit_in[0] = sat_inc(hit_ff[0]);
      end
      if (state_ff == S_CHECK) begin
         if (chk_skip) begin
            ptr_in[cur_k] = ptr_cur + 1'b1;
         end
         if (chk_hit) begin
            hit_in[cur_set_ff] = sat_inc(hit_ff[cur_set_ff]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Item and result datapath
   // ---------------------------------------------------------------------
   always_comb begin
      chrom_in     = chrom_ff;
      pos_in       = pos_ff;
      cur_set_in   = cur_set_ff;
      used_in      = used_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      rej_in       = rej_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         chrom_in   = in_chrom;
         pos_in     = in_pos;
         cur_set_in = SN_W'(1);
         used_in    = used_now;
         mask_in    = (in_action == ACT_QUERY) ? MASK_W'(1) : '0;
         count_in   = (in_action == ACT_COUNT && rd_idx_ok) ? hit_ff[rd_sel] : '0;
         rej_in     = (in_action == ACT_LOAD) && !(ld_idx_ok && !ld_full);
      end
      if (adv) begin
         cur_set_in = cur_set_ff + 1'b1;
      end
      // Membership bit for the set under test
      if (state_ff == S_CHECK && chk_hit) begin
         for (int b = 1; b < MASK_W; b++) begin
            if (32'(cur_set_ff) == b) begin
               mask_in[b] = 1'b1;
            end
         end
      end
      // Output register
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_mask_in  = mask_ff;
         rsp_count_in = count_ff;
         rsp_rej_in   = rej_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sets_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SETS; i++) begin
            cnt_ff[i] <= '0;
            ptr_ff[i] <= '0;
         end
         for (int i = 0; i <= NUM_SETS; i++) begin
            hit_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sets_ff      <= sets_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         hit_ff       <= hit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chrom_ff     <= chrom_in;
      pos_ff       <= pos_in;
      cur_set_ff   <= cur_set_in;
      used_ff      <= used_in;
      mask_ff      <= mask_in;
      count_ff     <= count_in;
      rej_ff       <= rej_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - MASK_W - COUNT_W - 1)'(0),
                        rsp_rej_ff, rsp_count_ff, rsp_mask_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> ptr_cur < cnt_cur)
      else $error("walk pointer past fill count during compare");

   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> $past(state_ff) == S_PROBE)
      else $error("compare without a preceding RAM read");

   a_reject_no_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rej_ff |-> rsp_mask_ff == '0)
      else $error("rejected load carries a membership mask");

   a_base_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && in_action == ACT_REWIND) |=> hit_ff[0] >= $past(hit_ff[0]))
      else $error("base hit count went down without rewind");

endmodule

// ===== tb/multi_set_interval_membership_sweep_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_set_interval_membership_sweep_unit_tb
// Self-checking bench for the interval membership sweep unit. A queue of
// request transactions (sorted interval loads and position queries with
// random content, plus count reads, rewinds and malformed items) feeds a
// stream driver. A cycle-free model of the sweep predicts one response per
// request, and the monitor compares every response field by field.
// ----------------------------------------------------------------------------
module multi_set_interval_membership_sweep_unit_tb;
   import msim_pkg::*;

   localparam int NSETS = 8;
   localparam int MAXIV = 1024;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int FILL_RUN = 32;
   localparam int unsigned COORD_MAX = 32'h0FFF_FFFF;

   // request fields, action on top, tdata order below it
   typedef struct packed {
      action_type            action;
      logic [27:0]           position;
      logic [27:0]           stop;
      logic [27:0]           start;
      logic                  chrom_valid;
      logic [CHROM_W-1:0]    chrom;
      logic [SEL_W-1:0]      set_index;
   } sweep_req_type;

   // response fields in rsp_tdata[41:0] order
   typedef struct packed {
      logic                  rejected;
      logic [COUNT_W-1:0]    count;
      logic [MASK_W-1:0]     mask;
   } sweep_rsp_type;

   typedef struct packed {
      bit [7:0]  chrom;
      bit [27:0] start;
      bit [27:0] stop;
   } region_span_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ACTION_W-1:0]    req_tuser = ACT_LOAD;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_W-1:0]       csr_data = '0;

   // model state
   region_span_type span_mem [1:NSETS][0:MAXIV-1];
   int           span_fill [1:NSETS];
   int           walk_ptr [1:NSETS];
   bit [31:0]    hit_tally [0:NSETS];
   logic [3:0]   sets_checked = '0;

   sweep_req_type request_backlog [$];
   sweep_rsp_type predicted_responses [$];
   sweep_req_type req_item;
   logic         req_taken = 1'b0;

   // stimulus bookkeeping
   int           items_queued = 0;
   int           chrom_cursor = 1;
   int           phase_no = -1;
   int           sender_idle_pct = 0;
   int           rsp_stall_pct = 0;
   logic         rsp_hold = 1'b0;
   int           mismatch_count = 0;
   int           rsp_seen = 0;
   logic [3:0]   cfg_plan [0:7] = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd8, 4'd1, 4'd6, 4'd8};

   multi_set_interval_membership_sweep_unit #(
      .NUM_SETS      (NSETS),
      .MAX_INTERVALS (MAXIV),
      .COORD_BITS    (28)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sweep model: one response per request, state updated in place
   function automatic sweep_rsp_type sweep_predict(input sweep_req_type rq);
      sweep_rsp_type   rs;
      region_span_type span;
      int           used;
      bit           walking;
      bit           hit;
      rs = '0;
      case (rq.action)
         ACT_LOAD: begin
            if (rq.set_index < 1 || rq.set_index > NSETS ||
                span_fill[rq.set_index] >= MAXIV) begin
               rs.rejected = 1'b1;
            end else begin
               span_mem[rq.set_index][span_fill[rq.set_index]] =
                  '{chrom: rq.chrom, start: rq.start, stop: rq.stop};
               span_fill[rq.set_index]++;
            end
         end
         ACT_QUERY: begin
            rs.mask = 9'd1;
            if (hit_tally[0] != '1) hit_tally[0]++;
            used = (sets_checked > NSETS) ? NSETS : sets_checked;
            if (rq.chrom_valid) begin
               for (int s = 1; s <= used; s++) begin
                  walking = 1'b1;
                  hit = 1'b0;
                  // forward-only walk: skip earlier chromosomes and spans
                  // that end before the position
                  while (walking && walk_ptr[s] < span_fill[s]) begin
                     span = span_mem[s][walk_ptr[s]];
                     if (rq.chrom > span.chrom) begin
                        walk_ptr[s]++;
                     end else if (rq.chrom == span.chrom) begin
                        if (span.start <= rq.position && span.stop >= rq.position) begin
                           hit = 1'b1;
                           walking = 1'b0;
                        end else if (span.start > rq.position) begin
                           walking = 1'b0;
                        end else begin
                           walk_ptr[s]++;
                        end
                     end else begin
                        walking = 1'b0;
                     end
                  end
                  if (hit) begin
                     rs.mask[s] = 1'b1;
                     if (hit_tally[s] != '1) hit_tally[s]++;
                  end
               end
            end
         end
         ACT_COUNT: begin
            if (rq.set_index <= NSETS) rs.count = hit_tally[rq.set_index];
         end
         ACT_REWIND: begin
            for (int s = 1; s <= NSETS; s++) walk_ptr[s] = 0;
            for (int s = 0; s <= NSETS; s++) hit_tally[s] = '0;
         end
         default: rs = '0;
      endcase
      return rs;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100)
         $display("ERROR @%0t: response %0d: %s", $realtime, rsp_seen, what);
      mismatch_count++;
   endtask

   task automatic queue_request(input action_type act, input int unsigned set_no,
                                input int unsigned chrom, input int unsigned chrom_valid,
                                input int unsigned lo, input int unsigned hi,
                                input int unsigned pos);
      sweep_req_type rq;
      rq = '{action: act, position: pos[27:0], stop: hi[27:0], start: lo[27:0],
             chrom_valid: chrom_valid[0], chrom: chrom[7:0], set_index: set_no[3:0]};
      request_backlog = {request_backlog, rq};
      items_queued++;
   endtask

   // One round: a few new chromosomes, each with sorted spans per set and
   // sorted queries behind them, plus some noise
   task automatic queue_sweep_round();
      int base, p, q, n, m, c_end;
      int unsigned lo;
      if ($urandom_range(0, 99) < 30) queue_request(ACT_REWIND, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom);
      c_end = chrom_cursor + $urandom_range(1, 3);
      for (int c = chrom_cursor; c < c_end; c++) begin
         base = $urandom_range(0, 28'hFFF_F000);
         for (int s = 1; s <= NSETS; s++) begin
            if ($urandom_range(0, 99) < 70) begin
               p = base;
               n = $urandom_range(0, 3);
               for (int i = 0; i < n; i++) begin
                  lo = p + $urandom_range(0, 40);
                  // now and then an empty span (stop below start)
                  queue_request(ACT_LOAD, s, c, $urandom, lo,
                                ($urandom_range(0, 99) < 5) ? lo - 1 : lo + $urandom_range(0, 30),
                                $urandom);
                  p = lo + $urandom_range(0, 50);
               end
            end
         end
         q = base;
         m = $urandom_range(3, 9);
         for (int i = 0; i < m; i++) begin
            q += $urandom_range(0, 25);
            queue_request(ACT_QUERY, $urandom, c, ($urandom_range(0, 99) >= 10) ? 1 : 0,
                          $urandom, $urandom, q);
            if ($urandom_range(0, 99) < 15)
               queue_request(ACT_COUNT, $urandom_range(0, 15), $urandom, $urandom,
                             $urandom, $urandom, $urandom);
         end
         chrom_cursor = c + 1;
      end
      // noise: a query anywhere, and a load at a bad index or behind the sweep
      if ($urandom_range(0, 99) < 50)
         queue_request(ACT_QUERY, $urandom, $urandom_range(0, 255), $urandom_range(0, 1),
                       $urandom, $urandom, $urandom);
      if ($urandom_range(0, 99) < 40) begin
         n = $urandom_range(0, 15);
         queue_request(ACT_LOAD, n,
                       (n >= 1 && n <= NSETS) ? $urandom_range(0, chrom_cursor - 1)
                                              : $urandom_range(0, 255),
                       $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // sets_in_use write, only while nothing is in flight
   task automatic write_sets_in_use(input logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sets_checked = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (request_backlog.size() != 0 || req_tvalid || predicted_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver and response ready, both at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_item = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_item.action;
               req_tdata  <= {{(REQ_TDATA_W-97){1'b0}}, req_item[96:0]};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Monitor: check responses, then predict for the request taken this edge
   always @(posedge clock) begin : monitor
      sweep_rsp_type want;
      sweep_rsp_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[41:0];
            if (predicted_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, tdata %h", rsp_tdata));
            end else begin
               want = predicted_responses.pop_front();
               if (got.mask !== want.mask)
                  report_mismatch($sformatf("membership_mask %h, expected %h",
                                            got.mask, want.mask));
               if (got.count !== want.count)
                  report_mismatch($sformatf("count_value %h, expected %h",
                                            got.count, want.count));
               if (got.rejected !== want.rejected)
                  report_mismatch($sformatf("load_rejected %b, expected %b",
                                            got.rejected, want.rejected));
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready) begin
            want = sweep_predict(req_item);
            predicted_responses = {predicted_responses, want};
         end
      end
   end

   // Long receiver hold-off while the sender keeps offering
   initial begin : long_hold
      wait (phase_no == 2);
      repeat (5) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin : watchdog
      #20_000_000;
      $display("** multi_set_interval_membership_sweep_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int phase_start;
      int p;
      int c;
      int i;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: sets above the limit, edges of spans and coordinates
      write_sets_in_use(4'd15);
      queue_request(ACT_COUNT, 0, 0, 0, '0, '0, '0);
      queue_request(ACT_LOAD, 0, 'hFF, 1, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_request(ACT_LOAD, 15, 'hFF, 1, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_request(ACT_LOAD, 1, 0, 0, 0, 0, '0);
      queue_request(ACT_LOAD, 1, 0, 0, 10, 20, '0);
      queue_request(ACT_LOAD, 2, 0, 0, 0, COORD_MAX, '0);
      queue_request(ACT_QUERY, 0, 0, 1, '0, '0, 0);
      queue_request(ACT_QUERY, 0, 0, 1, '0, '0, 5);
      queue_request(ACT_QUERY, 0, 0, 1, '0, '0, 20);
      queue_request(ACT_QUERY, 0, 0, 0, '0, '0, 15);   // unknown chromosome
      queue_request(ACT_QUERY, 0, 0, 1, '0, '0, COORD_MAX);
      queue_request(ACT_QUERY, 0, 1, 1, '0, '0, 0);
      queue_request(ACT_QUERY, 15, 'hFF, 1, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_request(ACT_COUNT, 0, 0, 0, '0, '0, '0);
      queue_request(ACT_COUNT, 1, 0, 0, '0, '0, '0);
      queue_request(ACT_COUNT, 2, 0, 0, '0, '0, '0);
      queue_request(ACT_COUNT, 9, 0, 0, '0, '0, '0);       // bad read index
      queue_request(ACT_COUNT, 15, 'hFF, 1, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_request(ACT_REWIND, 0, 0, 0, '0, '0, '0);
      queue_request(ACT_COUNT, 0, 0, 0, '0, '0, '0);
      queue_request(ACT_QUERY, 0, 0, 1, '0, '0, 15);
      wait_for_drain();

      // random phases, each with a register value from cfg_plan and one of four idle patterns
      for (phase_no = 0; phase_no < 8; phase_no++) begin
         write_sets_in_use(cfg_plan[phase_no]);
         case (phase_no % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin sender_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         phase_start = items_queued;
         while (items_queued - phase_start < ITEMS_PER_PHASE) queue_sweep_round();
         wait_for_drain();
      end

      // a long sorted run in the last set on a fresh chromosome
      write_sets_in_use(4'd8);
      sender_idle_pct = 14;
      rsp_stall_pct = 14;
      c = chrom_cursor;
      p = $urandom_range(0, 28'h800_0000);
      i = 0;
      while (i < FILL_RUN) begin
         queue_request(ACT_LOAD, NSETS, c, $urandom, p, p + $urandom_range(0, 20), $urandom);
         i++;
         if (i % 16 == 0)
            queue_request(ACT_QUERY, $urandom, c, 1, $urandom, $urandom,
                          p - $urandom_range(0, 10));
         p += $urandom_range(1, 30);
      end
      chrom_cursor = c + 1;
      queue_request(ACT_LOAD, NSETS, c, 1, p, p + 5, $urandom);
      queue_request(ACT_LOAD, NSETS, chrom_cursor, 1, $urandom, $urandom, $urandom);
      queue_request(ACT_COUNT, NSETS, $urandom, $urandom, $urandom, $urandom, $urandom);
      queue_request(ACT_REWIND, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      p = p / 2;
      for (int k = 0; k < 6; k++) begin
         queue_request(ACT_QUERY, $urandom, c, 1, $urandom, $urandom, p);
         p += $urandom_range(0, 200);
      end
      for (int k = 0; k <= NSETS; k++)
         queue_request(ACT_COUNT, k, $urandom, $urandom, $urandom, $urandom, $urandom);
      wait_for_drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** multi_set_interval_membership_sweep_unit: PASSED **");
      end else begin
         $display("** multi_set_interval_membership_sweep_unit: FAILED **");
      end
      $finish;
   end

endmodule
